// File: rtl/iirbq_pkg.sv
`default_nettype none

package iirbq_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 67;
    localparam int SAT_IN_W  = 68;
    localparam int SUM_W     = 36;
    localparam int CFG_W     = 4;
    localparam int IDX_W     = 6;
    localparam int ROUND_BITS = 30;
    localparam int GAIN_SHIFT_BASE = 14;
    localparam int GAIN_SHIFT_MAX  = 63;

    localparam int COEF_PER_SEC = 7;
    localparam int DLY_PER_SEC  = 4;

    typedef logic [2:0] tap_t;

    // coefficient word order within a section
    localparam tap_t TAP_A2    = 3'd0;
    localparam tap_t TAP_A1    = 3'd1;
    localparam tap_t TAP_B2    = 3'd2;
    localparam tap_t TAP_B1    = 3'd3;
    localparam tap_t TAP_B0    = 3'd4;
    localparam tap_t TAP_SHIFT = 3'd5;
    localparam tap_t TAP_GAIN  = 3'd6;
    localparam tap_t TAP_LAST  = 3'd7;

    // delay word order within a section
    localparam logic [1:0] DLY_Y2 = 2'd0;
    localparam logic [1:0] DLY_Y1 = 2'd1;
    localparam logic [1:0] DLY_X2 = 2'd2;
    localparam logic [1:0] DLY_X1 = 2'd3;

    localparam logic CFG_TOTAL  = 1'b0;
    localparam logic CFG_SERIES = 1'b1;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEC,
        S_MAC,
        S_ROUND,
        S_UPD,
        S_SHIFT1,
        S_SHIFT2,
        S_NEXT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        GM_PASS,
        GM_ROUND,
        GM_ZERO
    } gmode_t;

    typedef struct packed {
        logic mul_en;
        logic to_acc;
        logic acc_clr;
    } mac_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat_q31(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [SAT_IN_W-1:0] hi_lim;
        logic signed [SAT_IN_W-1:0] lo_lim;
        hi_lim = SAT_IN_W'(64'sh0000_0000_7FFF_FFFF);
        lo_lim = SAT_IN_W'(-64'sh0000_0000_8000_0000);
        if (v > hi_lim) begin
            sat_q31 = 32'sh7FFF_FFFF;
        end else if (v < lo_lim) begin
            sat_q31 = 32'sh8000_0000;
        end else begin
            sat_q31 = v[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/iirbq_mac.sv
`default_nettype none

module iirbq_mac
    import iirbq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mac_ctrl_t                 ctrl,
    input  wire logic signed [DATA_W-1:0]  op_a,
    input  wire logic signed [DATA_W-1:0]  op_b,
    output      logic signed [PROD_W-1:0]  prod,
    output      logic signed [DATA_W-1:0]  y_round
);

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       acc_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAT_IN_W-1:0] acc_rnd;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(op_a * op_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= 1'b0;
        end else begin
            acc_vld_reg <= ctrl.mul_en && ctrl.to_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (acc_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_rnd = (SAT_IN_W'(acc_reg) + (SAT_IN_W'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
    assign y_round = sat_q31(acc_rnd);
    assign prod    = prod_reg;

endmodule

`default_nettype wire

// File: rtl/iir_df1_biquad_cascade.sv
// Cascaded direct-form-1 biquad filter on Q31 samples. A request with
// s_func = 1 stores one coefficient word (a2, a1, b2, b1, b0, shift, gain per
// section) and gives no result; s_func = 0 filters one sample and gives one
// result on m_sample_out. Sections run one after another on a single shared
// 32x32 multiplier fed by a coefficient memory with one read port: an active
// section steps through setup, multiply/read, rounding, four delay writes,
// gain shift and group update; a section numbered MAX_SECTIONS or above goes
// from setup straight to group update, and each sample adds an accept and an
// output step. With sections_total of zero a sample passes through unfiltered.
// The block is not ready while a sample is in progress.
// Coefficients must be written before use; the delay lines clear on reset.
`default_nettype none

module iir_df1_biquad_cascade
    import iirbq_pkg::*;
#(
    parameter int MAX_SECTIONS = 8
)(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_wr_data,

    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire logic                      s_func,
    input  wire logic [IDX_W-1:0]          s_coef_index,
    input  wire logic signed [DATA_W-1:0]  s_data_value,

    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      logic signed [DATA_W-1:0]  m_sample_out
);

    localparam int COEF_WORDS = COEF_PER_SEC * MAX_SECTIONS;
    localparam int DLY_WORDS  = DLY_PER_SEC * MAX_SECTIONS;
    localparam int CW = $clog2(COEF_WORDS);
    localparam int DW = $clog2(DLY_WORDS);
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    state_t state_reg, state_next;
    tap_t   cnt_reg;

    logic [CFG_W-1:0] total_reg;
    logic [CFG_W-1:0] series_reg;
    logic [5:0]       total_eff;
    logic [5:0]       series_eff;

    logic [5:0]       j_reg;
    logic [CFG_W-1:0] i_reg;
    logic [5:0]       k_sec;
    logic [5:0]       j_step;
    logic             k_in_range;
    logic             grp_end;
    logic [SW-1:0]    k_row;

    logic signed [DATA_W-1:0] in_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] shift_reg;
    logic signed [DATA_W-1:0] gain_reg;
    logic signed [DATA_W-1:0] d1_reg;
    logic signed [DATA_W-1:0] d3_reg;
    logic signed [PROD_W-1:0] gadd_reg;
    gmode_t                   gmode_reg;
    logic [5:0]               gamt_reg;

    logic signed [DATA_W-1:0] coef_mem [COEF_WORDS];
    logic signed [DATA_W-1:0] dly_mem  [DLY_WORDS];
    logic signed [DATA_W-1:0] coef_q_reg;
    logic signed [DATA_W-1:0] dly_q_reg;
    logic                     rd_row_vld_reg;
    logic                     rd_act_reg;
    tap_t                     rd_tag_reg;
    logic [MAX_SECTIONS-1:0]  row_vld_reg;

    logic [31:0]              coef_wr_full;
    logic [31:0]              coef_rd_full;
    logic [31:0]              dly_full;
    logic [CW-1:0]            coef_rd_addr;
    logic [DW-1:0]            dly_addr;
    logic signed [DATA_W-1:0] dly_wr_data;
    logic signed [DATA_W-1:0] dly_op;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W-1:0] y_round;

    logic signed [33:0]       gshift;
    logic signed [PROD_W-1:0] gres;

    logic in_acc;
    logic out_load;

    assign total_eff  = (32'(total_reg) > MAX_SECTIONS) ? 6'(MAX_SECTIONS) : 6'(total_reg);
    assign series_eff = (series_reg == '0) ? 6'd1 : 6'(series_reg);

    assign k_sec      = j_reg + 6'(i_reg);
    assign k_in_range = 32'(k_sec) < MAX_SECTIONS;
    assign k_row      = k_sec[SW-1:0];
    assign grp_end    = (6'(i_reg) + 6'd1) == series_eff;
    assign j_step     = j_reg + series_eff;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid || m_ready);

    assign coef_wr_full = 32'(s_coef_index);
    assign coef_rd_full = 32'(k_sec) * COEF_PER_SEC + 32'(cnt_reg);
    assign dly_full     = 32'(k_sec) * DLY_PER_SEC + 32'(cnt_reg[1:0]);
    assign coef_rd_addr = coef_rd_full[CW-1:0];
    assign dly_addr     = dly_full[DW-1:0];

    assign dly_op = rd_row_vld_reg ? dly_q_reg : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_func == FUNC_FILTER) begin
                    state_next = (total_eff == '0) ? S_OUT : S_SEC;
                end
            end
            S_SEC:    state_next = k_in_range ? S_MAC : S_NEXT;
            S_MAC:    if (cnt_reg == TAP_LAST) state_next = S_ROUND;
            S_ROUND:  state_next = S_UPD;
            S_UPD:    if (cnt_reg[1:0] == DLY_X1) state_next = S_SHIFT1;
            S_SHIFT1: state_next = S_SHIFT2;
            S_SHIFT2: state_next = S_NEXT;
            S_NEXT: begin
                if (grp_end && j_step >= total_eff) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SEC;
                end
            end
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            total_reg  <= '0;
            series_reg <= CFG_W'(1);
            rd_act_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= (state_next != state_reg) ? '0 : cnt_reg + tap_t'(1);
            rd_act_reg <= (state_reg == S_MAC) && (cnt_reg <= TAP_GAIN);
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TOTAL) begin
                    total_reg <= cfg_wr_data;
                end else begin
                    series_reg <= cfg_wr_data;
                end
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // coefficient memory: write on request, registered read
    always_ff @(posedge aclk) begin
        if (in_acc && s_func == FUNC_COEF && coef_wr_full < COEF_WORDS) begin
            coef_mem[coef_wr_full[CW-1:0]] <= s_data_value;
        end
        coef_q_reg <= coef_mem[coef_rd_addr];
    end

    // delay memory: shift the section's history during update
    always_comb begin
        unique case (cnt_reg[1:0])
            DLY_Y2:  dly_wr_data = d1_reg;
            DLY_Y1:  dly_wr_data = y_reg;
            DLY_X2:  dly_wr_data = d3_reg;
            default: dly_wr_data = x_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            dly_mem[dly_addr] <= dly_wr_data;
        end
        dly_q_reg      <= dly_mem[dly_addr];
        rd_row_vld_reg <= row_vld_reg[k_row];
        rd_tag_reg     <= cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (state_reg == S_UPD && cnt_reg[1:0] == DLY_X1) begin
            row_vld_reg[k_row] <= 1'b1;
        end
    end

    always_comb begin
        mac_ctrl.mul_en  = 1'b0;
        mac_ctrl.to_acc  = 1'b0;
        mac_ctrl.acc_clr = (state_reg == S_SEC);
        mac_a = coef_q_reg;
        mac_b = (rd_tag_reg == TAP_B0) ? x_reg : dly_op;
        if (state_reg == S_UPD) begin
            mac_a = gain_reg;
            mac_b = y_reg;
            mac_ctrl.mul_en = (cnt_reg == '0);
        end else if (rd_act_reg && rd_tag_reg <= TAP_B0) begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.to_acc = 1'b1;
        end
    end

    iirbq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .prod    (prod),
        .y_round (y_round)
    );

    assign gshift = 34'(shift_reg) + 34'(GAIN_SHIFT_BASE);

    always_comb begin
        unique case (gmode_reg)
            GM_ROUND: gres = gadd_reg >>> gamt_reg;
            GM_ZERO:  gres = '0;
            default:  gres = gadd_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_act_reg) begin
            unique case (rd_tag_reg)
                TAP_A1:    d1_reg    <= dly_op;
                TAP_B1:    d3_reg    <= dly_op;
                TAP_SHIFT: shift_reg <= coef_q_reg;
                TAP_GAIN:  gain_reg  <= coef_q_reg;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    in_reg  <= s_data_value;
                    x_reg   <= s_data_value;
                    j_reg   <= '0;
                    i_reg   <= '0;
                    sum_reg <= (total_eff == '0) ? SUM_W'(s_data_value) : '0;
                end
            end
            S_ROUND: begin
                y_reg    <= y_round;
                gamt_reg <= gshift[5:0];
                if (gshift <= 34'sd0) begin
                    gmode_reg <= GM_PASS;
                end else if (gshift >= 34'(GAIN_SHIFT_MAX)) begin
                    gmode_reg <= GM_ZERO;
                end else begin
                    gmode_reg <= GM_ROUND;
                end
            end
            S_SHIFT1: begin
                if (gmode_reg == GM_ROUND) begin
                    gadd_reg <= prod + (PROD_W'(1) <<< (gamt_reg - 6'd1));
                end else begin
                    gadd_reg <= prod;
                end
            end
            S_SHIFT2: begin
                x_reg <= sat_q31(SAT_IN_W'(gres));
            end
            S_NEXT: begin
                if (grp_end) begin
                    sum_reg <= sum_reg + SUM_W'(x_reg);
                    j_reg   <= j_step;
                    i_reg   <= '0;
                    x_reg   <= in_reg;
                end else begin
                    i_reg <= i_reg + CFG_W'(1);
                end
            end
            default: ;
        endcase

        if (out_load) begin
            m_sample_out <= sat_q31(SAT_IN_W'(sum_reg));
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iirbq_pkg::*;

    localparam int NUM_SECTIONS = 8;
    localparam int COEF_WORDS = COEF_PER_SEC * NUM_SECTIONS;
    localparam int SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam logic signed [71:0] Q31_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q31_MIN = -72'sd2147483648;
    localparam logic signed [71:0] MAC_HALF = 72'sd536870912;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] UNITY_B0 = 32'sh4000_0000;
    localparam logic signed [31:0] UNITY_GAIN = 32'sd16384;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = CFG_TOTAL;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = FUNC_FILTER;
    logic [IDX_W-1:0] s_coef_index = '0;
    logic signed [DATA_W-1:0] s_data_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_sample_out;

    logic signed [31:0] coef_mem [COEF_WORDS];
    logic signed [31:0] delay_mem [DLY_PER_SEC * NUM_SECTIONS];
    logic [3:0] reg_total;
    logic [3:0] reg_series;
    logic signed [31:0] sample_out_q [$];

    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    longint cycle_count = 0;

    iir_df1_biquad_cascade #(
        .MAX_SECTIONS(NUM_SECTIONS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_coef_index(s_coef_index),
        .s_data_value(s_data_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample_out(m_sample_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic signed [31:0] clamp_q31(input logic signed [71:0] v);
        if (v > Q31_MAX) begin
            return WORD_MAX;
        end
        if (v < Q31_MIN) begin
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [71:0] mul_wide(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [71:0] wa;
        logic signed [71:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic logic signed [31:0] biquad_section(input int k,
                                                          input logic signed [31:0] x);
        logic signed [71:0] acc;
        logic signed [71:0] gained;
        logic signed [31:0] y;
        longint sh;
        int c;
        int d;
        c = COEF_PER_SEC * k;
        d = DLY_PER_SEC * k;
        acc = mul_wide(coef_mem[c + int'(TAP_A2)], delay_mem[d + int'(DLY_Y2)])
            + mul_wide(coef_mem[c + int'(TAP_A1)], delay_mem[d + int'(DLY_Y1)])
            + mul_wide(coef_mem[c + int'(TAP_B2)], delay_mem[d + int'(DLY_X2)])
            + mul_wide(coef_mem[c + int'(TAP_B1)], delay_mem[d + int'(DLY_X1)])
            + mul_wide(coef_mem[c + int'(TAP_B0)], x);
        acc = (acc + MAC_HALF) >>> ROUND_BITS;
        y = clamp_q31(acc);
        delay_mem[d + int'(DLY_Y2)] = delay_mem[d + int'(DLY_Y1)];
        delay_mem[d + int'(DLY_Y1)] = y;
        delay_mem[d + int'(DLY_X2)] = delay_mem[d + int'(DLY_X1)];
        delay_mem[d + int'(DLY_X1)] = x;
        gained = mul_wide(coef_mem[c + int'(TAP_GAIN)], y);
        sh = longint'(GAIN_SHIFT_BASE) + longint'(coef_mem[c + int'(TAP_SHIFT)]);
        if (sh >= GAIN_SHIFT_MAX) begin
            gained = '0;
        end else if (sh > 0) begin
            gained = (gained + (72'sd1 <<< (sh - 1))) >>> sh;
        end
        return clamp_q31(gained);
    endfunction

    function automatic logic signed [31:0] filter_sample(input logic signed [31:0] x);
        int total;
        int series;
        logic signed [71:0] sum;
        logic signed [31:0] v;
        total = (reg_total > NUM_SECTIONS) ? NUM_SECTIONS : int'(reg_total);
        series = (reg_series == 0) ? 1 : int'(reg_series);
        if (total == 0) begin
            return x;
        end
        sum = '0;
        for (int j = 0; j < total; j += series) begin
            v = x;
            for (int i = 0; i < series; i++) begin
                if (j + i < NUM_SECTIONS) begin
                    v = biquad_section(j + i, v);
                end
            end
            sum = sum + v;
        end
        return clamp_q31(sum);
    endfunction

    function automatic logic signed [31:0] extreme_word();
        case ($urandom_range(3))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] random_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) begin
            return $urandom;
        end
        if (sel < 8) begin
            return $signed($urandom) >>> 16;
        end
        return extreme_word();
    endfunction

    function automatic logic signed [31:0] random_coef(input int tap);
        int sel;
        sel = $urandom_range(9);
        if (sel >= 8) begin
            return $urandom;
        end
        if (tap == int'(TAP_SHIFT)) begin
            if (sel < 6) begin
                return int'($urandom_range(20)) - 14;
            end
            case ($urandom_range(6))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return 32'sd49;
                3: return 32'sd48;
                4: return -32'sd13;
                5: return -32'sd14;
                default: return -32'sd15;
            endcase
        end
        if (tap == int'(TAP_GAIN)) begin
            if (sel < 6) begin
                return 16384 + int'($urandom_range(8192)) - 4096;
            end
            return extreme_word();
        end
        if (sel < 6) begin
            if (tap == int'(TAP_A1) || tap == int'(TAP_A2)) begin
                return $signed($urandom) >>> (2 + $urandom_range(3));
            end
            return $signed($urandom) >>> (1 + $urandom_range(3));
        end
        return extreme_word();
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        if (mismatch_count < 50) begin
            $display("MISMATCH at cycle %0d: %s: m_sample_out got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        logic signed [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (sample_out_q.size() == 0) begin
                report_mismatch("result with no request pending", m_sample_out, '0);
            end else begin
                want = sample_out_q.pop_front();
                if (m_sample_out !== want) begin
                    report_mismatch("sample value", m_sample_out, want);
                end
            end
        end
    end

    task automatic send_request(input logic func, input logic [IDX_W-1:0] idx,
                                input logic signed [31:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_coef_index <= idx;
        s_data_value <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (func == FUNC_COEF) begin
            if (idx < COEF_WORDS) begin
                coef_mem[idx] = value;
            end
        end else begin
            sample_out_q.push_back(filter_sample(value));
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sample_out_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [3:0] total, input logic [3:0] series);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TOTAL;
        cfg_wr_data <= total;
        @(posedge aclk);
        cfg_index <= CFG_SERIES;
        cfg_wr_data <= series;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_total = total;
        reg_series = series;
    endtask

    task automatic set_coef(input int sec, input tap_t tap, input logic signed [31:0] value);
        send_request(FUNC_COEF, IDX_W'(COEF_PER_SEC * sec + int'(tap)), value);
    endtask

    task automatic test_passthrough();
        send_request(FUNC_FILTER, '0, 32'sd0);
        send_request(FUNC_FILTER, '1, WORD_MAX);
        send_request(FUNC_FILTER, '0, WORD_MIN);
        send_request(FUNC_COEF, IDX_W'(COEF_WORDS), 32'sh5555_5555);
        send_request(FUNC_COEF, '1, 32'shAAAA_AAAA);
        send_request(FUNC_FILTER, '0, -32'sd1);
        wait_drain();
    endtask

    task automatic load_coefficients();
        int tap;
        for (int idx = 0; idx < COEF_WORDS; idx++) begin
            tap = idx % COEF_PER_SEC;
            if (idx < COEF_PER_SEC) begin
                if (tap == int'(TAP_B0)) begin
                    send_request(FUNC_COEF, IDX_W'(idx), UNITY_B0);
                end else if (tap == int'(TAP_GAIN)) begin
                    send_request(FUNC_COEF, IDX_W'(idx), UNITY_GAIN);
                end else begin
                    send_request(FUNC_COEF, IDX_W'(idx), 32'sd0);
                end
            end else begin
                send_request(FUNC_COEF, IDX_W'(idx), random_coef(tap));
            end
        end
        wait_drain();
    endtask

    task automatic test_gain_shift();
        logic signed [31:0] shifts [5];
        shifts = '{-32'sd14, 32'sd49, 32'sd48, WORD_MIN, WORD_MAX};
        write_config(4'd1, 4'd1);
        send_request(FUNC_FILTER, '0, WORD_MAX);
        send_request(FUNC_FILTER, '0, WORD_MIN);
        foreach (shifts[i]) begin
            set_coef(0, TAP_SHIFT, shifts[i]);
            send_request(FUNC_FILTER, '0, WORD_MAX);
        end
        set_coef(0, TAP_SHIFT, 32'sd0);
        set_coef(0, TAP_GAIN, WORD_MIN);
        send_request(FUNC_FILTER, '0, 32'sd123456789);
        set_coef(0, TAP_GAIN, UNITY_GAIN);
        wait_drain();
    endtask

    task automatic test_wide_mac();
        for (int t = int'(TAP_A2); t <= int'(TAP_B0); t++) begin
            set_coef(0, tap_t'(t), WORD_MIN);
        end
        repeat (3) send_request(FUNC_FILTER, '0, WORD_MIN);
        send_request(FUNC_FILTER, '0, WORD_MAX);
        wait_drain();
    endtask

    task automatic test_section_counts();
        logic [3:0] totals [5];
        logic [3:0] series [5];
        totals = '{4'd15, 4'd8, 4'd15, 4'd8, 4'd2};
        series = '{4'd0, 4'd3, 4'd15, 4'd8, 4'd1};
        foreach (totals[i]) begin
            write_config(totals[i], series[i]);
            send_request(FUNC_FILTER, '0, extreme_word());
            send_request(FUNC_FILTER, '0, random_sample());
            wait_drain();
        end
    endtask

    task automatic random_request();
        int sel;
        int idx;
        sel = $urandom_range(99);
        if (sel < 80) begin
            send_request(FUNC_FILTER, IDX_W'($urandom_range(63)), random_sample());
        end else if (sel < 95) begin
            idx = $urandom_range(COEF_WORDS - 1);
            send_request(FUNC_COEF, IDX_W'(idx), random_coef(idx % COEF_PER_SEC));
        end else begin
            send_request(FUNC_COEF, IDX_W'($urandom_range(63, COEF_WORDS)), $urandom);
        end
    endtask

    task automatic test_random_traffic();
        logic [3:0] totals [12];
        logic [3:0] series [12];
        totals = '{4'd8, 4'd8, 4'd15, 4'd0, 4'd8, 4'd3, 4'd8, 4'd5, 4'd1, 4'd6, 4'd0, 4'd0};
        series = '{4'd1, 4'd8, 4'd0, 4'd1, 4'd3, 4'd2, 4'd7, 4'd15, 4'd1, 4'd4, 4'd0, 4'd0};
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 85;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 85;
                end
                default: begin
                    sender_idle_pct = 32;
                    receiver_stall_pct = 32;
                end
            endcase
            if (phase >= 10) begin
                write_config(4'($urandom_range(15)), 4'($urandom_range(15)));
            end else begin
                write_config(totals[phase], series[phase]);
            end
            repeat (30) random_request();
            wait_drain();
        end
    endtask

    initial begin
        foreach (coef_mem[i]) coef_mem[i] = '0;
        foreach (delay_mem[i]) delay_mem[i] = '0;
        reg_total = 4'd0;
        reg_series = 4'd1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_passthrough();
        load_coefficients();
        test_gain_shift();
        test_wide_mac();
        test_section_counts();
        test_random_traffic();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: iir_df1_biquad_cascade.f
rtl/iirbq_pkg.sv
rtl/iirbq_mac.sv
rtl/iir_df1_biquad_cascade.sv
tb/testbench.sv
